// ===== hdl/okss_pkg.sv =====
package okss_pkg;

  // Store sizing
  localparam int CAPACITY   = 64;
  localparam int KEY_WIDTH  = 32;
  localparam int RANK_W     = 8;
  localparam int ACT_W      = 3;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int RANK_CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Result gathering: cells are OR-reduced in groups, then across groups
  localparam int GRP   = 8;
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MEMBER = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SUCC   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PRED   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_KTH    = 3'd5;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]            action;
    logic signed [KEY_WIDTH-1:0] key;
    logic [RANK_W-1:0]           rank;
  } req_t;

  typedef struct packed {
    logic                        found;
    logic signed [KEY_WIDTH-1:0] value;
    logic                        status;
  } rsp_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic                        cmp_en;
    logic                        ins;
    logic                        era;
    logic [ACT_W-1:0]            action;
    logic signed [KEY_WIDTH-1:0] key;
    logic [RANK_W-1:0]           rank;
  } cell_ctl_t;

endpackage

// ===== hdl/okss_cell.sv =====
module okss_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  okss_pkg::cell_ctl_t                  ctl,
  input  logic [okss_pkg::IDX_W-1:0]           idx,
  input  logic signed [okss_pkg::KEY_WIDTH-1:0] lo_key,
  input  logic                                 lo_valid,
  input  logic                                 lo_lt,
  input  logic                                 lo_gt,
  input  logic signed [okss_pkg::KEY_WIDTH-1:0] hi_key,
  input  logic                                 hi_valid,
  input  logic                                 hi_lt,
  output logic signed [okss_pkg::KEY_WIDTH-1:0] key_q,
  output logic                                 valid,
  output logic                                 lt,
  output logic                                 gt,
  output logic                                 eq,
  output logic                                 hit,
  output logic signed [okss_pkg::KEY_WIDTH-1:0] hit_key
);
  import okss_pkg::*;

  logic                        rank_hit;
  logic                        pick;
  logic signed [KEY_WIDTH-1:0] key_next;
  logic                        valid_next;

  // Compare the held key against the request key
  assign lt = valid && ($signed(key_q) <  $signed(ctl.key));
  assign eq = valid && ($signed(key_q) == $signed(ctl.key));
  assign gt = valid && ($signed(key_q) >  $signed(ctl.key));

  assign rank_hit = (RANK_CMP_W'(ctl.rank) == (RANK_CMP_W'(idx) + RANK_CMP_W'(1)));

  // Decide whether this cell holds the answer of a query
  always_comb begin
    case (ctl.action)
      ACT_SUCC: pick = gt && !lo_gt;
      ACT_PRED: pick = lt && !hi_lt;
      ACT_KTH:  pick = valid && rank_hit;
      default:  pick = 1'b0;
    endcase
  end

  // Shift up on insert, shift down on erase, hold below the split point
  always_comb begin
    key_next   = key_q;
    valid_next = valid;
    if (ctl.ins && !lt) begin
      if (lo_lt) begin
        key_next   = ctl.key;
        valid_next = 1'b1;
      end else begin
        key_next   = lo_key;
        valid_next = lo_valid;
      end
    end else if (ctl.era && !lt) begin
      key_next   = hi_key;
      valid_next = hi_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      valid <= valid_next;
      if (ctl.cmp_en) begin
        hit <= pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
    if (ctl.cmp_en) begin
      hit_key <= pick ? key_q : '0;
    end
  end

endmodule

// ===== hdl/ordered_key_set_rank_select_core.sv =====
// Ordered key set with member test, successor, predecessor and k-th smallest.
// Request channel (req_valid/req_ready, req) carries action, key and rank;
// response channel (rsp_valid/rsp_ready, rsp) returns exactly one response
// per request: found, value and status.
// Keys sit in a sorted chain of 64 cells. Insert and erase shift the part of
// the chain above the split point by one cell, all of its cells at once.
// Order of work: the compare in the cells is registered in each cell, the
// grouped OR of the cell answers is registered per group, and the final OR
// across groups is loaded into the output register. The next request is
// taken once the response is registered, so one request is in flight at a
// time.
// A stalled receiver holds the response in the output register; a new
// request can still be accepted and worked on, and its response waits in
// the final stage until the output register frees up.
// Reset (rst, synchronous) empties the set and drops any pending response.
// Insert into a full set of an absent key is dropped with status 1.
module ordered_key_set_rank_select_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  okss_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output okss_pkg::rsp_t rsp
);
  import okss_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  req_t       cur;

  cell_ctl_t  ctl;
  logic       present;
  logic       full;

  logic signed [KEY_WIDTH-1:0] ckey   [CAPACITY];
  logic signed [KEY_WIDTH-1:0] chkey  [CAPACITY];
  logic [CAPACITY-1:0]         cvalid;
  logic [CAPACITY-1:0]         clt;
  logic [CAPACITY-1:0]         cgt;
  logic [CAPACITY-1:0]         ceq;
  logic [CAPACITY-1:0]         chit;

  logic                        is_member;
  logic                        present_r;
  logic                        status_r;

  logic [NGRP-1:0]             grp_found;
  logic signed [KEY_WIDTH-1:0] grp_key      [NGRP];
  logic [NGRP-1:0]             grp_found_next;
  logic signed [KEY_WIDTH-1:0] grp_key_next [NGRP];

  logic                        any_hit;
  logic signed [KEY_WIDTH-1:0] any_key;
  logic                        out_load;

  assign req_ready = (state == S_IDLE) && !rst;
  assign out_load  = (state == S_OUT) && (!rsp_valid || rsp_ready);

  // Set-wide flags from the cell compares and the top cell's valid bit
  assign present = |ceq;
  assign full    = cvalid[CAPACITY-1];

  // Broadcast the current request to the chain
  always_comb begin
    ctl.cmp_en = (state == S_CMP);
    ctl.action = cur.action;
    ctl.key    = cur.key;
    ctl.rank   = cur.rank;
    ctl.ins    = (state == S_CMP) && (cur.action == ACT_INSERT) && !present && !full;
    ctl.era    = (state == S_CMP) && (cur.action == ACT_ERASE) && present;
  end

  // Sorted chain of cells, each wired to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] lo_key;
    logic                        lo_valid;
    logic                        lo_lt;
    logic                        lo_gt;
    logic signed [KEY_WIDTH-1:0] hi_key;
    logic                        hi_valid;
    logic                        hi_lt;

    if (i == 0) begin : g_lo_edge
      assign lo_key   = '0;
      assign lo_valid = 1'b1;
      assign lo_lt    = 1'b1;
      assign lo_gt    = 1'b0;
    end else begin : g_lo
      assign lo_key   = ckey[i-1];
      assign lo_valid = cvalid[i-1];
      assign lo_lt    = clt[i-1];
      assign lo_gt    = cgt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi_edge
      assign hi_key   = '0;
      assign hi_valid = 1'b0;
      assign hi_lt    = 1'b0;
    end else begin : g_hi
      assign hi_key   = ckey[i+1];
      assign hi_valid = cvalid[i+1];
      assign hi_lt    = clt[i+1];
    end

    okss_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .idx      (IDX_W'(i)),
      .lo_key   (lo_key),
      .lo_valid (lo_valid),
      .lo_lt    (lo_lt),
      .lo_gt    (lo_gt),
      .hi_key   (hi_key),
      .hi_valid (hi_valid),
      .hi_lt    (hi_lt),
      .key_q    (ckey[i]),
      .valid    (cvalid[i]),
      .lt       (clt[i]),
      .gt       (cgt[i]),
      .eq       (ceq[i]),
      .hit      (chit[i]),
      .hit_key  (chkey[i])
    );
  end

  // Reduce cell answers within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_found_next[g] = 1'b0;
      grp_key_next[g]   = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < CAPACITY) begin
          grp_found_next[g] = grp_found_next[g] | chit[g * GRP + j];
          grp_key_next[g]   = grp_key_next[g] | chkey[g * GRP + j];
        end
      end
    end
  end

  // Reduce across groups
  always_comb begin
    any_hit = 1'b0;
    any_key = '0;
    for (int g = 0; g < NGRP; g++) begin
      any_hit = any_hit | grp_found[g];
      any_key = any_key | grp_key[g];
    end
  end

  // Advance the request sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_valid) state_next = S_CMP;
      S_CMP:   state_next = S_RED;
      S_RED:   state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the request, per-request flags, group results and response
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    if (state == S_CMP) begin
      is_member <= (cur.action == ACT_MEMBER);
      present_r <= present;
      status_r  <= ((cur.action == ACT_INSERT) && !present && full) ? ST_FULL : ST_OK;
    end
    if (state == S_RED) begin
      grp_found <= grp_found_next;
      for (int g = 0; g < NGRP; g++) begin
        grp_key[g] <= grp_key_next[g];
      end
    end
    if (out_load) begin
      rsp.found  <= is_member ? present_r : any_hit;
      rsp.value  <= any_key;
      rsp.status <= status_r;
    end
  end

endmodule

// ===== hdl/okss_checker.sv =====
module okss_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input okss_pkg::rsp_t rsp
);
  import okss_pkg::*;

  // Hold a stalled response unchanged
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed or dropped");

  // One request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  // A dropped insert never reports a found key
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> !rsp.found && (rsp.value == '0))
    else $error("full status with nonzero answer");

  // Nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && (rst || req_ready))
    else $error("response or busy state survived reset");

endmodule

bind ordered_key_set_rank_select_core okss_checker u_okss_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== test/tb_ordered_key_set_rank_select_core.sv =====
module tb_ordered_key_set_rank_select_core;
  import okss_pkg::*;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Sorted copy of the key set, updated as each request is accepted
  logic signed [KEY_WIDTH-1:0] set_keys [CAPACITY];
  int set_count = 0;

  rsp_t pending_rsps [$];
  int mismatch_cnt = 0;
  bit idle_on = 1'b1;
  int ready_hold = 0;

  ordered_key_set_rank_select_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Mostly back-to-back, now and then a short or a long pause
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the key set and return the response it must produce
  function automatic rsp_t predict_set_response(req_t r);
    rsp_t res;
    logic signed [KEY_WIDTH-1:0] k;
    int pos;
    int nxt;
    bit present;
    res = '0;
    k = r.key;
    pos = 0;
    while (pos < set_count && set_keys[pos] < k) pos++;
    present = (pos < set_count) && (set_keys[pos] == k);
    case (r.action)
      ACT_INSERT: begin
        if (!present) begin
          if (set_count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (int i = set_count; i > pos; i--) set_keys[i] = set_keys[i-1];
            set_keys[pos] = k;
            set_count++;
          end
        end
      end
      ACT_ERASE: begin
        if (present) begin
          for (int i = pos; i < set_count - 1; i++) set_keys[i] = set_keys[i+1];
          set_count--;
        end
      end
      ACT_MEMBER: begin
        res.found = present;
      end
      ACT_SUCC: begin
        nxt = present ? pos + 1 : pos;
        if (nxt < set_count) begin
          res.found = 1'b1;
          res.value = set_keys[nxt];
        end
      end
      ACT_PRED: begin
        if (pos > 0) begin
          res.found = 1'b1;
          res.value = set_keys[pos-1];
        end
      end
      ACT_KTH: begin
        if (int'(r.rank) >= 1 && int'(r.rank) <= set_count) begin
          res.found = 1'b1;
          res.value = set_keys[int'(r.rank) - 1];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Present one request, hold it until accepted, then record its response
  task automatic send_request(logic [ACT_W-1:0] action, logic signed [KEY_WIDTH-1:0] key,
                              logic [RANK_W-1:0] rank);
    req_t r;
    int gap;
    r.action = action;
    r.key = key;
    r.rank = rank;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_rsps.push_back(predict_set_response(r));
  endtask

  // Hold off new requests until every response is back
  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsps.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_WIDTH-1:0] extreme_key();
    case ($urandom_range(0, 5))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return KEY_MIN + 1;
      3: return KEY_MAX - 1;
      4: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [KEY_WIDTH-1:0] stored_key();
    return set_keys[$urandom_range(0, set_count - 1)];
  endfunction

  // Check each response against the oldest expectation; stall the receiver at random
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsps.size() == 0) begin
          $error("response with no request pending: found=%0d value=%0d status=%0d",
                 rsp.found, rsp.value, rsp.status);
          mismatch_cnt++;
        end else begin
          want = pending_rsps.pop_front();
          if (rsp.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp.found);
            mismatch_cnt++;
          end
          if (rsp.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, rsp.value);
            mismatch_cnt++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatch_cnt++;
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (!idle_on || $urandom_range(0, 1)) begin
        rsp_ready <= 1'b1;
        ready_hold = $urandom_range(1, 16);
      end else begin
        rsp_ready <= 1'b0;
        ready_hold = pick_gap();
      end
    end
  end

  // Extremes, every request type and the corner cases on a small set
  task automatic test_directed();
    send_request(ACT_KTH, '0, 8'd1);
    send_request(ACT_SUCC, '0, '0);
    send_request(ACT_PRED, '0, '0);
    send_request(ACT_MEMBER, '0, '0);
    send_request(ACT_ERASE, 5, '0);
    send_request(ACT_INSERT, KEY_MIN, '0);
    send_request(ACT_INSERT, KEY_MAX, '0);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, '1, '0);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_MEMBER, KEY_MIN, '0);
    send_request(ACT_MEMBER, 1, '0);
    send_request(ACT_SUCC, KEY_MAX, '0);
    send_request(ACT_SUCC, -2, '0);
    send_request(ACT_PRED, KEY_MIN, '0);
    send_request(ACT_PRED, KEY_MAX, '0);
    send_request(ACT_KTH, '0, 8'd0);
    send_request(ACT_KTH, '0, 8'd4);
    send_request(ACT_KTH, '0, 8'd5);
    send_request(ACT_KTH, KEY_MAX, 8'd255);
    send_request(ACT_SPARE_LO, KEY_MAX, 8'd1);
    send_request(ACT_SPARE_HI, '1, 8'd255);
    send_request(ACT_ERASE, KEY_MIN, '0);
    send_request(ACT_ERASE, KEY_MIN, '0);
    send_request(ACT_KTH, '0, 8'd1);
  endtask

  // Fill the store with wide keys, hit the full case, then empty it again
  task automatic test_fill_and_drain();
    int guard;
    guard = 0;
    while (set_count < CAPACITY && guard < 400) begin
      guard++;
      if ($urandom_range(0, 3) == 0)
        send_request(logic'($urandom_range(0, 1)) ? ACT_SUCC : ACT_PRED, $urandom(), '0);
      else
        send_request(ACT_INSERT, $urandom(), '0);
    end
    repeat (6) send_request(ACT_INSERT, $urandom(), '0);
    repeat (3) send_request(ACT_INSERT, stored_key(), '0);
    send_request(ACT_INSERT, extreme_key(), '0);
    send_request(ACT_KTH, '0, RANK_W'(CAPACITY));
    send_request(ACT_KTH, '0, RANK_W'(CAPACITY + 1));
    send_request(ACT_MEMBER, stored_key(), '0);
    drain_responses();
    guard = 0;
    while (set_count > 0 && guard < 400) begin
      guard++;
      case ($urandom_range(0, 5))
        0: send_request(ACT_KTH, '0, RANK_W'($urandom_range(0, set_count + 1)));
        1: send_request(ACT_ERASE, $urandom(), '0);
        2: send_request(ACT_SUCC, stored_key(), '0);
        default: send_request(ACT_ERASE, stored_key(), '0);
      endcase
    end
    drain_responses();
  endtask

  // Random requests; keys mostly from a narrow window so they collide often
  task automatic test_random_mix(int n_items, int insert_pct);
    logic [ACT_W-1:0] action;
    logic signed [KEY_WIDTH-1:0] key;
    logic [RANK_W-1:0] rank;
    int r;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        action = ACT_INSERT;
      end else if (r < insert_pct + 20) begin
        action = ACT_ERASE;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 22) action = ACT_MEMBER;
        else if (r < 44) action = ACT_SUCC;
        else if (r < 66) action = ACT_PRED;
        else if (r < 94) action = ACT_KTH;
        else action = logic'($urandom_range(0, 1)) ? ACT_SPARE_HI : ACT_SPARE_LO;
      end
      r = $urandom_range(0, 99);
      if (r < 55 || (r < 75 && set_count == 0)) key = int'($urandom_range(0, 48)) - 24;
      else if (r < 75) key = stored_key();
      else if (r < 93) key = $urandom();
      else key = extreme_key();
      if ($urandom_range(0, 99) < 80) rank = RANK_W'($urandom_range(0, set_count + 1));
      else rank = RANK_W'($urandom_range(0, 255));
      send_request(action, key, rank);
    end
  endtask

  // Safety net against a hung handshake
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_drain();
    test_random_mix(240, 45);
    idle_on = 1'b0;
    test_random_mix(90, 30);
    idle_on = 1'b1;
    drain_responses();
    test_random_mix(250, 20);
    drain_responses();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
